// ===== design/smo_pkg.sv =====
`default_nettype none
package smo_pkg;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [3:0] {
        OP_OFFSET = 4'd0,
        OP_MUL    = 4'd1,
        OP_DIV    = 4'd2,
        OP_MOD    = 4'd3,
        OP_FLOOR  = 4'd4,
        OP_CEIL   = 4'd5,
        OP_ROUND  = 4'd6,
        OP_MAX    = 4'd7,
        OP_MIN    = 4'd8,
        OP_ABS    = 4'd9
    } op_t;

    typedef enum logic [2:0] {
        REG_OPERATION = 3'd0,
        REG_COUNT     = 3'd1,
        REG_FIRST     = 3'd2,
        REG_SECOND    = 3'd3,
        REG_THIRD     = 3'd4
    } reg_idx_t;
endpackage
`default_nettype wire

// ===== design/smo_div.sv =====
`default_nettype none
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Dividend: 64-bit magnitude, divisor: 32-bit magnitude (nonzero).
// Payload side-band travels alongside.
module smo_div #(
    parameter int SB = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [63:0]   dividend,
    input  wire logic [31:0]   divisor,
    input  wire logic [SB-1:0] side_in,
    output logic               out_valid,
    output logic [63:0]        quotient,
    output logic [32:0]        remainder,
    output logic [SB-1:0]      side_out
);
    localparam int N = 64;

    logic          v_reg [N+1];
    logic [63:0]   q_reg [N+1];
    logic [32:0]   r_reg [N+1];
    logic [31:0]   d_reg [N+1];
    logic [SB-1:0] s_reg [N+1];

    always_comb
    begin
        q_reg[0] = dividend;
        r_reg[0] = '0;
        d_reg[0] = divisor;
        s_reg[0] = side_in;
        v_reg[0] = in_valid;
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            logic [33:0]   trial_next;
            logic [32:0]   rsh_next;
            always_comb
            begin
                rsh_next   = {r_reg[g][31:0], q_reg[g][63]};
                trial_next = {1'b0, rsh_next} - {2'b00, d_reg[g]};
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[g+1] <= 1'b0;
                else if (en)
                    v_reg[g+1] <= v_reg[g];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_reg[g+1] <= d_reg[g];
                    s_reg[g+1] <= s_reg[g];
                    if (!trial_next[33])
                    begin
                        r_reg[g+1] <= trial_next[32:0];
                        q_reg[g+1] <= {q_reg[g][62:0], 1'b1};
                    end
                    else
                    begin
                        r_reg[g+1] <= rsh_next;
                        q_reg[g+1] <= {q_reg[g][62:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[N];
    assign quotient  = q_reg[N];
    assign remainder = r_reg[N];
    assign side_out  = s_reg[N];
endmodule
`default_nettype wire

// ===== design/selectable_math_operator.sv =====
`default_nettype none
// Selectable math operator on signed fixed-point samples (FRAC_BITS fraction
// bits). Fully pipelined: one transaction per cycle unless the output stalls. The
// result passes through 68 register stages, most of them in the 64-stage
// bit-per-stage divider that every sample passes through regardless of
// operation. Stalls on the output freeze the whole pipe.
// Configure only while idle.
module selectable_math_operator #(
    parameter int FRAC_BITS = smo_pkg::FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic signed [31:0] sample,
    input  wire logic [1:0]  component,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] result,
    output logic             saturated
);
    localparam logic signed [65:0] ONE  = 66'sd1 <<< FRAC_BITS;
    localparam logic signed [65:0] HALF = (FRAC_BITS > 0) ? (ONE >>> 1) : 66'sd0;
    localparam logic [31:0] FMASK = 32'((64'd1 << FRAC_BITS) - 64'd1);
    localparam int SB = 4 + 1 + 1 + 1 + 66;

    logic [3:0]  operation_reg;
    logic [1:0]  count_reg;
    logic signed [31:0] opnd_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operation_reg <= '0;
            count_reg     <= 2'd1;
            opnd_reg[0]   <= '0;
            opnd_reg[1]   <= '0;
            opnd_reg[2]   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                smo_pkg::REG_OPERATION: operation_reg <= cfg_data[3:0];
                smo_pkg::REG_COUNT:     count_reg     <= cfg_data[1:0];
                smo_pkg::REG_FIRST:     opnd_reg[0]   <= cfg_data;
                smo_pkg::REG_SECOND:    opnd_reg[1]   <= cfg_data;
                smo_pkg::REG_THIRD:     opnd_reg[2]   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage 1: operand select, register sample
    logic [1:0] sel;
    always_comb
    begin
        sel = 2'd0;
        case (count_reg)
            2'd2: sel = {1'b0, component[0]};
            2'd3: sel = (component == 2'd3) ? 2'd0 : component;
            default: sel = 2'd0;
        endcase
    end

    logic        v1_reg;
    logic signed [31:0] s1_reg, o1_reg;
    logic [3:0]  op1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= sample;
            o1_reg  <= opnd_reg[sel];
            op1_reg <= operation_reg;
        end
    end

    // stage 2: multiply / simple ops / divider operand prep
    logic signed [63:0] prod;
    assign prod = s1_reg * o1_reg;

    logic signed [65:0] s1x, o1x, simple;
    logic signed [31:0] fl;
    always_comb
    begin
        s1x = 66'(s1_reg);
        o1x = 66'(o1_reg);
        fl  = s1_reg & ~FMASK;
        simple = s1x;
        case (op1_reg)
            smo_pkg::OP_OFFSET: simple = s1x + o1x;
            smo_pkg::OP_FLOOR:  simple = 66'(fl);
            smo_pkg::OP_CEIL:   simple = ((s1_reg & FMASK) != '0) ? 66'(fl) + ONE : 66'(fl);
            smo_pkg::OP_ROUND:
            begin
                if ((66'(s1_reg & FMASK) > HALF) ||
                    (FRAC_BITS > 0 && 66'(s1_reg & FMASK) == HALF &&
                     s1_reg[FRAC_BITS > 30 ? 30 : FRAC_BITS]))
                    simple = 66'(fl) + ONE;
                else
                    simple = 66'(fl);
            end
            smo_pkg::OP_MAX: simple = (s1x > o1x) ? s1x : o1x;
            smo_pkg::OP_MIN: simple = (s1x < o1x) ? s1x : o1x;
            smo_pkg::OP_ABS: simple = s1_reg[31] ? -s1x : s1x;
            default: simple = s1x;
        endcase
    end

    logic        v2_reg;
    logic signed [63:0] p2_reg;
    logic signed [65:0] simple2_reg;
    logic [3:0]  op2_reg;
    logic [63:0] dvd2_reg;
    logic [31:0] dvs2_reg;
    logic        neg2_reg, sneg2_reg, zero2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg      <= prod;
            simple2_reg <= simple;
            op2_reg     <= op1_reg;
            if (op1_reg == smo_pkg::OP_DIV)
                dvd2_reg <= 64'(s1_reg[31] ? -s1x : s1x) << FRAC_BITS;
            else
                dvd2_reg <= 64'(s1_reg[31] ? -s1x : s1x);
            dvs2_reg  <= o1_reg[31] ? 32'(-o1x) : o1_reg;
            neg2_reg  <= s1_reg[31] ^ o1_reg[31];
            sneg2_reg <= s1_reg[31];
            zero2_reg <= (o1_reg == '0);
        end
    end

    // stage 3: multiply rounding, value select, zero-divisor guard
    logic signed [65:0] mul3;
    assign mul3 = (66'(p2_reg) + HALF) >>> FRAC_BITS;

    logic        v3_reg;
    logic signed [65:0] val3_reg;
    logic [3:0]  op3_reg;
    logic [63:0] dvd3_reg;
    logic [31:0] dvs3_reg;
    logic        neg3_reg, sneg3_reg, zero3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val3_reg  <= (op2_reg == smo_pkg::OP_MUL) ? mul3 : simple2_reg;
            op3_reg   <= op2_reg;
            dvd3_reg  <= dvd2_reg;
            dvs3_reg  <= zero2_reg ? 32'd1 : dvs2_reg;
            neg3_reg  <= neg2_reg;
            sneg3_reg <= sneg2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // divider stages
    logic        vd;
    logic [63:0] qd;
    logic [32:0] rd;
    logic [SB-1:0] sd;
    smo_div #(.SB(SB)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .dividend  (dvd3_reg),
        .divisor   (dvs3_reg),
        .side_in   ({op3_reg, neg3_reg, sneg3_reg, zero3_reg, val3_reg}),
        .out_valid (vd),
        .quotient  (qd),
        .remainder (rd),
        .side_out  (sd)
    );

    logic [3:0]  opd;
    logic        negd, snegd, zerod;
    logic signed [65:0] vald, fin;
    assign {opd, negd, snegd, zerod, vald} = sd;

    always_comb
    begin
        case (opd)
            smo_pkg::OP_DIV:
                fin = zerod ? 66'sd0 : (negd ? -$signed({2'b00, qd}) : $signed({2'b00, qd}));
            smo_pkg::OP_MOD:
                fin = zerod ? 66'sd0 : (snegd ? -66'($signed({1'b0, rd})) : 66'($signed({1'b0, rd})));
            default: fin = vald;
        endcase
    end

    // output register with saturation
    logic signed [31:0] result_reg;
    logic        sat_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vd;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (fin > 66'sd2147483647)
            begin
                result_reg <= 32'h7FFFFFFF;
                sat_reg    <= 1'b1;
            end
            else if (fin < -66'sd2147483648)
            begin
                result_reg <= 32'h80000000;
                sat_reg    <= 1'b1;
            end
            else
            begin
                result_reg <= fin[31:0];
                sat_reg    <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign saturated = sat_reg;
endmodule
`default_nettype wire
